// ===== rtl/fmm_pkg.sv =====
// ----------------------------------------------------------------------------
// fmm_pkg
// Shared types and constants for the float32 matrix multiply block.
// ----------------------------------------------------------------------------
package fmm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int DIM_W       = 4;
	localparam int QDEPTH      = 4;

	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	localparam logic [1:0] CFG_A_ROWS     = 2'd0;
	localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [1:0] CFG_B_COLS     = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  elem_row;
		logic [2:0]  elem_col;
		logic [31:0] elem_value;
	} in_word_t;

	typedef struct packed {
		logic [31:0] product_value;
		logic [2:0]  out_row;
		logic [2:0]  out_col;
		logic        is_last;
	} out_word_t;

	typedef enum logic [1:0] {
		OP_LOAD_A,
		OP_LOAD_B,
		OP_RUN
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
	} op_t;

endpackage

// ===== rtl/fmm_front.sv =====
// ----------------------------------------------------------------------------
// fmm_front
// Classifies and queues input words, drops out-of-range loads and unused cmds.
// ----------------------------------------------------------------------------
module fmm_front import fmm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_word,
	output logic     q_valid,
	input  logic     q_pop,
	output op_t      q_head
);

	localparam int PW = $clog2(QDEPTH);

	op_t              fifo_q [QDEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             accept;
	logic             push;
	logic             in_range;
	op_t              op;

	assign in_stall = (count_q == (PW+1)'(QDEPTH));
	assign accept   = in_valid && !in_stall;
	assign in_range = ({1'b0, in_word.elem_row} < 4'(MAX_DIM)) &&
		({1'b0, in_word.elem_col} < 4'(MAX_DIM));

	always_comb begin
		op.row   = in_word.elem_row;
		op.col   = in_word.elem_col;
		op.value = in_word.elem_value;
		op.kind  = OP_RUN;
		push     = 1'b0;
		unique case (in_word.command)
			CMD_LOAD_A: begin
				op.kind = OP_LOAD_A;
				push    = accept && in_range;
			end
			CMD_LOAD_B: begin
				op.kind = OP_LOAD_B;
				push    = accept && in_range;
			end
			CMD_COMPUTE: begin
				push    = accept;
			end
			default: begin
				// drop the unused command
				push    = 1'b0;
			end
		endcase
	end

	assign q_valid = (count_q != '0);
	assign q_head  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(QDEPTH)) else $error("queue count over depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != '0) else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/fmm_back.sv =====
// ----------------------------------------------------------------------------
// fmm_back
// Element stores, multiply-add sequencer with a shared normalize/round unit,
// and the output register.
// ----------------------------------------------------------------------------
module fmm_back import fmm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  op_t              q_head,
	input  logic [DIM_W-1:0] nr,
	input  logic [DIM_W-1:0] nk,
	input  logic [DIM_W-1:0] nc,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_MPREP = 4'd3;
	localparam logic [3:0] ST_MRND  = 4'd4;
	localparam logic [3:0] ST_ALN   = 4'd5;
	localparam logic [3:0] ST_SUM   = 4'd6;
	localparam logic [3:0] ST_APREP = 4'd7;
	localparam logic [3:0] ST_ARND  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	localparam logic [31:0] QNAN_DEF = 32'hFFC0_0000;
	localparam logic [31:0] QBIT     = 32'h0040_0000;

	function automatic logic [5:0] lzc48(input logic [47:0] x);
		logic [5:0] z;
		z = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (x[i]) z = 6'(47 - i);
		end
		return z;
	endfunction

	// t has its leading one at bit 47 and weight 2^(be-127) there
	function automatic logic [31:0] fround(input logic [47:0] t,
		input logic signed [10:0] be, input logic sgn);
		logic signed [10:0] eo;
		logic signed [10:0] e2;
		logic signed [10:0] denorm_sh;
		logic [6:0]         sh;
		logic [95:0]        w;
		logic [23:0]        sig;
		logic               g;
		logic               st;
		logic [24:0]        s25;
		logic [23:0]        sig2;
		if (be < 11'sd1) begin
			denorm_sh = 11'sd1 - be;
			sh        = (denorm_sh > 11'sd48) ? 7'd48 : denorm_sh[6:0];
			eo        = 11'sd1;
		end else begin
			denorm_sh = 11'sd0;
			sh        = 7'd0;
			eo        = be;
		end
		w    = {t, 48'b0} >> sh;
		sig  = w[95:72];
		g    = w[71];
		st   = |w[70:0];
		s25  = {1'b0, sig} + 25'(g & (st | sig[0]));
		sig2 = s25[24] ? s25[24:1] : s25[23:0];
		e2   = s25[24] ? eo + 11'sd1 : eo;
		if (e2 >= 11'sd255) return {sgn, 8'hFF, 23'b0};
		else if (!sig2[23]) return {sgn, 8'h00, sig2[22:0]};
		else return {sgn, e2[7:0], sig2[22:0]};
	endfunction

	logic [31:0] a_mem [DEPTH];
	logic [31:0] b_mem [DEPTH];
	logic [31:0] a_rd_q;
	logic [31:0] b_rd_q;

	logic [3:0]       st_q;
	logic [DIM_W-1:0] r_q;
	logic [DIM_W-1:0] c_q;
	logic [DIM_W-1:0] k_q;
	logic             out_valid_q;
	out_word_t        out_word_q;

	logic [31:0]        prod_q;
	logic [31:0]        acc_q;
	logic [47:0]        nx_q;
	logic signed [10:0] nbe_q;
	logic               nsgn_q;
	logic               spec_q;
	logic [31:0]        specv_q;
	logic [47:0]        small_q;
	logic               sub_q;

	logic          wr_a;
	logic          wr_b;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic          out_free;
	logic          is_last;
	logic          elem_start;

	assign out_free  = !out_valid_q || !out_stall;
	assign is_last   = (r_q + 1'b1 == nr) && (c_q + 1'b1 == nc);
	assign q_pop     = (st_q == ST_IDLE) && q_valid;
	assign wr_addr   = AW'(q_head.row * MAX_DIM + q_head.col);
	assign wr_a      = q_pop && (q_head.kind == OP_LOAD_A);
	assign wr_b      = q_pop && (q_head.kind == OP_LOAD_B);
	assign rd_en     = (st_q == ST_RD);
	assign rd_addr_a = AW'(r_q * MAX_DIM + k_q);
	assign rd_addr_b = AW'(k_q * MAX_DIM + c_q);
	assign elem_start = (q_pop && q_head.kind == OP_RUN) ||
		(st_q == ST_OUT && out_free);

	always_ff @(posedge clk) begin
		if (wr_a) a_mem[wr_addr] <= q_head.value;
		if (rd_en) a_rd_q <= a_mem[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (wr_b) b_mem[wr_addr] <= q_head.value;
		if (rd_en) b_rd_q <= b_mem[rd_addr_b];
	end

	// ---------------- multiply operand decode ----------------
	logic        ma_nan, ma_inf, ma_zero, mb_nan, mb_inf, mb_zero, m_sgn;
	logic [7:0]  ma_ef, mb_ef;
	logic [23:0] ma_sig, mb_sig;
	logic        m_spec;
	logic [31:0] m_specv;
	logic signed [10:0] m_be;

	always_comb begin
		ma_nan  = (a_rd_q[30:23] == 8'hFF) && (a_rd_q[22:0] != '0);
		ma_inf  = (a_rd_q[30:23] == 8'hFF) && (a_rd_q[22:0] == '0);
		ma_zero = (a_rd_q[30:0] == '0);
		mb_nan  = (b_rd_q[30:23] == 8'hFF) && (b_rd_q[22:0] != '0);
		mb_inf  = (b_rd_q[30:23] == 8'hFF) && (b_rd_q[22:0] == '0);
		mb_zero = (b_rd_q[30:0] == '0);
		m_sgn   = a_rd_q[31] ^ b_rd_q[31];
		ma_ef   = (a_rd_q[30:23] == 8'h00) ? 8'd1 : a_rd_q[30:23];
		mb_ef   = (b_rd_q[30:23] == 8'h00) ? 8'd1 : b_rd_q[30:23];
		ma_sig  = {a_rd_q[30:23] != 8'h00, a_rd_q[22:0]};
		mb_sig  = {b_rd_q[30:23] != 8'h00, b_rd_q[22:0]};
		m_be    = $signed({3'b0, ma_ef}) + $signed({3'b0, mb_ef}) - 11'sd126;
		m_spec  = 1'b1;
		priority if (ma_nan) m_specv = a_rd_q | QBIT;
		else if (mb_nan) m_specv = b_rd_q | QBIT;
		else if ((ma_inf && mb_zero) || (ma_zero && mb_inf)) m_specv = QNAN_DEF;
		else if (ma_inf || mb_inf) m_specv = {m_sgn, 8'hFF, 23'b0};
		else if (ma_zero || mb_zero) m_specv = {m_sgn, 31'b0};
		else begin
			m_specv = '0;
			m_spec  = 1'b0;
		end
	end

	// ---------------- add operand decode and align ----------------
	logic        x_nan, x_inf, y_nan, y_inf;
	logic [31:0] big, sml;
	logic [7:0]  big_ef, sml_ef, dexp;
	logic [6:0]  dsh;
	logic [95:0] sw;
	logic        a_spec;
	logic [31:0] a_specv;

	always_comb begin
		x_nan  = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != '0);
		x_inf  = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] == '0);
		y_nan  = (prod_q[30:23] == 8'hFF) && (prod_q[22:0] != '0);
		y_inf  = (prod_q[30:23] == 8'hFF) && (prod_q[22:0] == '0);
		if (prod_q[30:0] > acc_q[30:0]) begin
			big = prod_q;
			sml = acc_q;
		end else begin
			big = acc_q;
			sml = prod_q;
		end
		big_ef = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
		sml_ef = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
		dexp   = big_ef - sml_ef;
		dsh    = (dexp > 8'd48) ? 7'd48 : dexp[6:0];
		sw     = {1'b0, sml[30:23] != 8'h00, sml[22:0], 23'b0, 48'b0} >> dsh;
		a_spec = 1'b1;
		priority if (x_nan) a_specv = acc_q | QBIT;
		else if (y_nan) a_specv = prod_q | QBIT;
		else if (x_inf && y_inf && (acc_q[31] != prod_q[31])) a_specv = QNAN_DEF;
		else if (x_inf) a_specv = acc_q;
		else if (y_inf) a_specv = prod_q;
		else if (acc_q[30:0] == '0 && prod_q[30:0] == '0)
			a_specv = {acc_q[31] & prod_q[31], 31'b0};
		else begin
			a_specv = '0;
			a_spec  = 1'b0;
		end
	end

	logic [47:0] sum;
	logic [5:0]  lz;
	logic [31:0] rnd;
	assign sum = sub_q ? nx_q - small_q : nx_q + small_q;
	assign lz  = lzc48(nx_q);
	// one round unit serves both the product and the sum
	assign rnd = spec_q ? specv_q : fround(nx_q, nbe_q, nsgn_q);

	// datapath registers
	always_ff @(posedge clk) begin
		if (elem_start) acc_q <= 32'h0;
		unique case (st_q)
			ST_MUL: begin
				nx_q    <= ma_sig * mb_sig;
				nbe_q   <= m_be;
				nsgn_q  <= m_sgn;
				spec_q  <= m_spec;
				specv_q <= m_specv;
			end
			ST_MPREP, ST_APREP: begin
				nx_q  <= nx_q << lz;
				nbe_q <= nbe_q - $signed({5'b0, lz});
			end
			ST_MRND: begin
				prod_q <= rnd;
			end
			ST_ALN: begin
				nx_q    <= {1'b0, big[30:23] != 8'h00, big[22:0], 23'b0};
				small_q <= sw[95:48] | {47'b0, |sw[47:0]};
				sub_q   <= big[31] ^ sml[31];
				nsgn_q  <= big[31];
				nbe_q   <= $signed({3'b0, big_ef}) + 11'sd1;
				spec_q  <= a_spec;
				specv_q <= a_specv;
			end
			ST_SUM: begin
				nx_q <= sum;
				// exact cancellation gives +0
				if (!spec_q && sum == '0) begin
					spec_q  <= 1'b1;
					specv_q <= 32'h0;
				end
			end
			ST_ARND: begin
				acc_q <= rnd;
			end
			default: begin
			end
		endcase
		if (st_q == ST_OUT && out_free) begin
			out_word_q.product_value <= acc_q;
			out_word_q.out_row       <= r_q[2:0];
			out_word_q.out_col       <= c_q[2:0];
			out_word_q.is_last       <= is_last;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop && q_head.kind == OP_RUN && nr != '0 && nc != '0) begin
						r_q  <= '0;
						c_q  <= '0;
						k_q  <= '0;
						st_q <= (nk == '0) ? ST_OUT : ST_RD;
					end
				end
				ST_RD:    st_q <= ST_MUL;
				ST_MUL:   st_q <= ST_MPREP;
				ST_MPREP: st_q <= ST_MRND;
				ST_MRND:  st_q <= ST_ALN;
				ST_ALN:   st_q <= ST_SUM;
				ST_SUM:   st_q <= ST_APREP;
				ST_APREP: st_q <= ST_ARND;
				ST_ARND: begin
					k_q  <= k_q + 1'b1;
					st_q <= (k_q + 1'b1 == nk) ? ST_OUT : ST_RD;
				end
				ST_OUT: begin
					if (out_free) begin
						k_q <= '0;
						if (is_last) begin
							st_q <= ST_IDLE;
						end else begin
							if (c_q + 1'b1 == nc) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
							st_q <= (nk == '0) ? ST_OUT : ST_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef NO_ASSERTIONS
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && out_free) |=> out_valid_q)
		else $error("output word not loaded");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |-> (k_q < nk)) else $error("inner index past size");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (st_q == ST_IDLE)) else $error("pop while busy");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |-> (r_q < nr && c_q < nc)) else $error("position out of range");
`endif

endmodule

// ===== rtl/float_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// float_matrix_multiply
// Float32 matrix multiply C = A x B with on-chip element stores.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall   | in_word (in_word_t)
//  out     | output    | out_valid/out_stall | out_word (out_word_t)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A load word is written to its store as the back end pops it; the front
//  queue holds four. For each product element, every inner step reads
//  both stores, multiplies, and runs the shared normalize/round unit
//  twice (product, then sum) in sequence with the accumulator.
//  Reset clears control, queue and dimension registers (all dimensions 8).
//  The front stalls only when the queue is full; the back holds when the
//  output register is occupied and stalled.
// ----------------------------------------------------------------------------
module float_matrix_multiply import fmm_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	logic [DIM_W-1:0] a_rows_q;
	logic [DIM_W-1:0] inner_size_q;
	logic [DIM_W-1:0] b_cols_q;
	logic [DIM_W-1:0] nr, nk, nc;
	logic             q_valid;
	logic             q_pop;
	op_t              q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q     <= DIM_W'(8);
			inner_size_q <= DIM_W'(8);
			b_cols_q     <= DIM_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_A_ROWS:     a_rows_q     <= cfg_data;
				CFG_INNER_SIZE: inner_size_q <= cfg_data;
				CFG_B_COLS:     b_cols_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// saturate dimensions to the store size
	assign nr = (a_rows_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : a_rows_q;
	assign nk = (inner_size_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : inner_size_q;
	assign nc = (b_cols_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : b_cols_q;

	fmm_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_head   (q_head)
	);

	fmm_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head),
		.nr        (nr),
		.nk        (nk),
		.nc        (nc),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== sim/tb_float_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// tb_float_matrix_multiply
// Drives element loads and product runs into the float32 matrix multiply,
// under random sender bursts and receiver stalls, and checks every product
// word against a bit-exact integer float32 multiply/add predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_float_matrix_multiply;
	import fmm_pkg::*;

	localparam int LIMIT = 4000000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;

	class fmm_scoreboard;
		logic [31:0] a_mem[64];
		logic [31:0] b_mem[64];
		int unsigned rows_reg, inner_reg, cols_reg;
		out_word_t pending[$];
		int errors;

		function new();
			rows_reg = 8;
			inner_reg = 8;
			cols_reg = 8;
			errors = 0;
			foreach (a_mem[i]) begin
				a_mem[i] = '0;
				b_mem[i] = '0;
			end
		endfunction

		function void set_dim(logic [1:0] idx, logic [3:0] val);
			case (idx)
				CFG_A_ROWS: rows_reg = val;
				CFG_INNER_SIZE: inner_reg = val;
				CFG_B_COLS: cols_reg = val;
				default: ;
			endcase
		endfunction

		function int unsigned clamp_dim(int unsigned d);
			return d > 8 ? 8 : d;
		endfunction

		// value = m * 2^e, rounded to nearest even into binary32
		function logic [31:0] round_pack(logic s, int e, longint m);
			int p, lsbw, sh;
			longint keep, bits;
			logic rb, st;
			if (m == 0)
				return {s, 31'b0};
			p = 0;
			for (int i = 62; i >= 0; i--) begin
				if (m[i]) begin
					p = i;
					break;
				end
			end
			lsbw = p + e - 23;
			if (lsbw < -149)
				lsbw = -149;
			sh = lsbw - e;
			if (sh <= 0) begin
				keep = m << (-sh);
			end else if (sh > 60) begin
				keep = 0;
			end else begin
				keep = m >> sh;
				rb = m[sh-1];
				st = (m & ((64'd1 << (sh - 1)) - 1)) != 0;
				if (rb && (st || keep[0]))
					keep++;
			end
			bits = (longint'(lsbw + 149) << 23) + keep;
			if (bits >= 64'h7F800000)
				return {s, 31'h7F800000};
			return {s, bits[30:0]};
		endfunction

		function void unpack(logic [31:0] x, output longint m, output int e);
			m = (x[30:23] != 0) ? {40'd1, x[22:0]} : {41'd0, x[22:0]};
			e = ((x[30:23] != 0) ? int'(x[30:23]) : 1) - 150;
		endfunction

		function bit is_nan(logic [31:0] x);
			return x[30:23] == 8'hFF && x[22:0] != 0;
		endfunction

		function bit is_inf(logic [31:0] x);
			return x[30:0] == 31'h7F800000;
		endfunction

		function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
			longint ma, mb;
			int ea, eb;
			if (is_nan(a)) return a | 32'h00400000;
			if (is_nan(b)) return b | 32'h00400000;
			if (is_inf(a) || is_inf(b)) begin
				if (a[30:0] == 0 || b[30:0] == 0)
					return DEFAULT_NAN;
				return {a[31] ^ b[31], 31'h7F800000};
			end
			if (a[30:0] == 0 || b[30:0] == 0)
				return {a[31] ^ b[31], 31'b0};
			unpack(a, ma, ea);
			unpack(b, mb, eb);
			return round_pack(a[31] ^ b[31], ea + eb, ma * mb);
		endfunction

		function longint align(longint m, int e, int ce);
			if (e >= ce)
				return m << (e - ce);
			if (e - ce < -60)
				return 1;
			return (m >> (ce - e)) | (((m << (64 - (ce - e))) != 0) ? 1 : 0);
		endfunction

		function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
			longint ma, mb, mag;
			int ea, eb, hi, lo, ce;
			logic s;
			if (is_nan(a)) return a | 32'h00400000;
			if (is_nan(b)) return b | 32'h00400000;
			if (is_inf(a) && is_inf(b) && a[31] != b[31]) return DEFAULT_NAN;
			if (is_inf(a)) return a;
			if (is_inf(b)) return b;
			if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
			if (a[30:0] == 0) return b;
			if (b[30:0] == 0) return a;
			unpack(a, ma, ea);
			unpack(b, mb, eb);
			hi = ea > eb ? ea : eb;
			lo = ea > eb ? eb : ea;
			ce = (hi - 32 > lo) ? hi - 32 : lo;
			ma = align(ma, ea, ce);
			mb = align(mb, eb, ce);
			if (a[31] == b[31]) begin
				mag = ma + mb;
				s = a[31];
			end else if (ma >= mb) begin
				mag = ma - mb;
				s = a[31];
			end else begin
				mag = mb - ma;
				s = b[31];
			end
			if (mag == 0)
				return 32'h0;
			return round_pack(s, ce, mag);
		endfunction

		function void note_input(in_word_t w);
			int unsigned nr, nk, nc;
			logic [31:0] acc;
			out_word_t o;
			case (w.command)
				CMD_LOAD_A: a_mem[{w.elem_row, w.elem_col}] = w.elem_value;
				CMD_LOAD_B: b_mem[{w.elem_row, w.elem_col}] = w.elem_value;
				CMD_COMPUTE: begin
					nr = clamp_dim(rows_reg);
					nk = clamp_dim(inner_reg);
					nc = clamp_dim(cols_reg);
					for (int r = 0; r < nr; r++) begin
						for (int c = 0; c < nc; c++) begin
							acc = 32'h0;
							for (int k = 0; k < nk; k++)
								acc = fadd(acc, fmul(a_mem[r*8+k], b_mem[k*8+c]));
							o.product_value = acc;
							o.out_row = 3'(r);
							o.out_col = 3'(c);
							o.is_last = (r == nr - 1) && (c == nc - 1);
							pending.push_back(o);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_word_t w);
			out_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected product word, expected none, actual %h", $time, w);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (w.product_value !== e.product_value) begin
				$display("%0t: product_value expected %h actual %h", $time,
					e.product_value, w.product_value);
				errors++;
			end
			if (w.out_row !== e.out_row) begin
				$display("%0t: out_row expected %0d actual %0d", $time, e.out_row, w.out_row);
				errors++;
			end
			if (w.out_col !== e.out_col) begin
				$display("%0t: out_col expected %0d actual %0d", $time, e.out_col, w.out_col);
				errors++;
			end
			if (w.is_last !== e.is_last) begin
				$display("%0t: is_last expected %0d actual %0d", $time, e.is_last, w.is_last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	fmm_scoreboard sb = new();
	int unsigned cycles = 0;
	int burst_left = 0;
	bit a_written[64];
	bit b_written[64];
	int unsigned cur_rows = 8, cur_inner = 8, cur_cols = 8;

	always #5 clk = ~clk;

	float_matrix_multiply u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(in_word);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_word);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stall pattern: free, light, heavy and alternating stretches
	always @(negedge clk) begin
		case ((cycles / 97) % 4)
			0: out_stall = 1'b0;
			1: out_stall = ($urandom_range(0, 9) < 3);
			2: out_stall = ($urandom_range(0, 9) < 8);
			default: out_stall = ((cycles / 5) % 2 == 0);
		endcase
	end

	task automatic send_word(logic [1:0] cmd, logic [2:0] r, logic [2:0] c, logic [31:0] v);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_valid = 1'b1;
		in_word = '{command: cmd, elem_row: r, elem_col: c, elem_value: v};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
		if (burst_left == 0)
			in_valid = 1'b0;
		if (cmd == CMD_LOAD_A) a_written[{r, c}] = 1'b1;
		if (cmd == CMD_LOAD_B) b_written[{r, c}] = 1'b1;
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		// a run without products may still be busy
		repeat (600) @(negedge clk);
	endtask

	task automatic write_dim(logic [1:0] idx, logic [3:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_dim(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
		case (idx)
			CFG_A_ROWS: cur_rows = val > 8 ? 8 : val;
			CFG_INNER_SIZE: cur_inner = val > 8 ? 8 : val;
			default: cur_cols = val > 8 ? 8 : val;
		endcase
	endtask

	function automatic logic [31:0] rand_float();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return {1'($urandom()), 31'h0};
			2: return {1'($urandom()), 8'hFF, ($urandom_range(0, 1) ? 23'h0 : 23'($urandom()))};
			3: return {1'($urandom()), 8'h00, 23'($urandom())};
			default: return {1'($urandom()), 8'($urandom_range(118, 136)), 23'($urandom())};
		endcase
	endfunction

	// load whatever the next run reads that was never written, then start it
	task automatic run_product();
		for (int r = 0; r < cur_rows; r++)
			for (int k = 0; k < cur_inner; k++)
				if (!a_written[r*8+k])
					send_word(CMD_LOAD_A, 3'(r), 3'(k), rand_float());
		for (int k = 0; k < cur_inner; k++)
			for (int c = 0; c < cur_cols; c++)
				if (!b_written[k*8+c])
					send_word(CMD_LOAD_B, 3'(k), 3'(c), rand_float());
		send_word(CMD_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
	endtask

	task automatic random_phase(int n_items, int pct_run);
		for (int i = 0; i < n_items; i++) begin
			case ($urandom_range(0, 99) < pct_run ? 2 : $urandom_range(0, 20))
				2: run_product();
				20: send_word(CMD_UNUSED, 3'($urandom()), 3'($urandom()), $urandom());
				default: send_word(2'($urandom_range(0, 1)), 3'($urandom()), 3'($urandom()),
					rand_float());
			endcase
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: 2x2x2 with special values
		write_dim(CFG_A_ROWS, 4'd2);
		write_dim(CFG_INNER_SIZE, 4'd2);
		write_dim(CFG_B_COLS, 4'd2);
		send_word(CMD_LOAD_A, 3'd0, 3'd0, 32'h7F800000);
		send_word(CMD_LOAD_A, 3'd0, 3'd1, 32'h3F800000);
		send_word(CMD_LOAD_A, 3'd1, 3'd0, 32'h80000000);
		send_word(CMD_LOAD_A, 3'd1, 3'd1, 32'h00000001);
		send_word(CMD_LOAD_B, 3'd0, 3'd0, 32'h00000000);
		send_word(CMD_LOAD_B, 3'd0, 3'd1, 32'h7FA12345);
		send_word(CMD_LOAD_B, 3'd1, 3'd0, 32'h7F7FFFFF);
		send_word(CMD_LOAD_B, 3'd1, 3'd1, 32'h3F000000);
		send_word(CMD_LOAD_A, 3'd7, 3'd7, 32'hFFFFFFFF);
		send_word(CMD_LOAD_B, 3'd7, 3'd7, 32'h00000000);
		send_word(CMD_COMPUTE, 3'd0, 3'd0, 32'h0);
		send_word(CMD_UNUSED, 3'd7, 3'd7, 32'hFFFFFFFF);
		send_word(CMD_LOAD_A, 3'd0, 3'd0, 32'hFF800000);
		send_word(CMD_LOAD_B, 3'd0, 3'd1, 32'h7F800000);
		send_word(CMD_LOAD_A, 3'd1, 3'd0, 32'h7F7FFFFF);
		send_word(CMD_LOAD_B, 3'd0, 3'd0, 32'h7F7FFFFF);
		send_word(CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFFFFFF);
		wait_idle();
		write_dim(CFG_INNER_SIZE, 4'd0);
		send_word(CMD_COMPUTE, 3'd0, 3'd0, 32'h0);
		wait_idle();
		write_dim(CFG_A_ROWS, 4'd0);
		write_dim(CFG_INNER_SIZE, 4'd2);
		send_word(CMD_COMPUTE, 3'd0, 3'd0, 32'h0);
		wait_idle();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin
					write_dim(CFG_A_ROWS, 4'd8);
					write_dim(CFG_INNER_SIZE, 4'd8);
					write_dim(CFG_B_COLS, 4'd8);
				end
				1: begin
					write_dim(CFG_A_ROWS, 4'd15);
					write_dim(CFG_INNER_SIZE, 4'd1);
					write_dim(CFG_B_COLS, 4'd15);
				end
				2: begin
					write_dim(CFG_A_ROWS, 4'd3);
					write_dim(CFG_INNER_SIZE, 4'd15);
					write_dim(CFG_B_COLS, 4'd0);
				end
				default: begin
					write_dim(CFG_A_ROWS, 4'($urandom_range(1, 4)));
					write_dim(CFG_INNER_SIZE, 4'($urandom_range(0, 5)));
					write_dim(CFG_B_COLS, 4'($urandom_range(1, 4)));
				end
			endcase
			random_phase(ph < 2 ? 6 : 24, ph < 2 ? 30 : 12);
			if (ph == 6)
				wait_idle();
			random_phase(ph < 2 ? 2 : 6, 20);
			wait_idle();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fmm_pkg.sv
rtl/fmm_front.sv
rtl/fmm_back.sv
rtl/float_matrix_multiply.sv
sim/tb_float_matrix_multiply.sv
